// ===== sv/cvm_pkg.sv =====
// shared types, constants and lookup tables for the chiptune voice modulator
// no dependencies
package cvm_pkg;

    localparam int DEF_VOICES = 4;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_TRIG = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [3:0] FX_DUTY   = 4'd1;
    localparam logic [3:0] FX_VSLIDE = 4'd2;
    localparam logic [3:0] FX_GLIDE  = 4'd3;
    localparam logic [3:0] FX_BEND   = 4'd5;
    localparam logic [3:0] FX_SWEEP  = 4'd6;
    localparam logic [3:0] FX_VOL    = 4'd8;
    localparam logic [3:0] FX_WAVE   = 4'd9;
    localparam logic [3:0] FX_VIB    = 4'd10;
    localparam logic [3:0] FX_RELN   = 4'd11;
    localparam logic [3:0] FX_ABSN   = 4'd12;

    localparam logic [7:0]  MAX_NOTE = 8'd83;
    localparam logic [7:0]  NOTE_OFS = 8'd48;
    localparam logic [15:0] DUTY_HI  = 16'he000;
    localparam logic [15:0] DUTY_LO  = 16'h2000;

    function automatic logic [15:0] ftab(input logic [6:0] i);
        logic [15:0] t [84];
        t = '{16'h010b, 16'h011b, 16'h012c, 16'h013e, 16'h0151, 16'h0165, 16'h017a,
              16'h0191, 16'h01a9, 16'h01c2, 16'h01dd, 16'h01f9, 16'h0217, 16'h0237,
              16'h0259, 16'h027d, 16'h02a3, 16'h02cb, 16'h02f5, 16'h0322, 16'h0352,
              16'h0385, 16'h03ba, 16'h03f3, 16'h042f, 16'h046f, 16'h04b2, 16'h04fa,
              16'h0546, 16'h0596, 16'h05eb, 16'h0645, 16'h06a5, 16'h070a, 16'h0775,
              16'h07e6, 16'h085f, 16'h08de, 16'h0965, 16'h09f4, 16'h0a8c, 16'h0b2c,
              16'h0bd6, 16'h0c8b, 16'h0d4a, 16'h0e14, 16'h0eea, 16'h0fcd, 16'h10be,
              16'h11bd, 16'h12cb, 16'h13e9, 16'h1518, 16'h1659, 16'h17ad, 16'h1916,
              16'h1a94, 16'h1c28, 16'h1dd5, 16'h1f9b, 16'h217c, 16'h237a, 16'h2596,
              16'h27d3, 16'h2a31, 16'h2cb3, 16'h2f5b, 16'h322c, 16'h3528, 16'h3851,
              16'h3bab, 16'h3f37, 16'h42f9, 16'h46f5, 16'h4b2d, 16'h4fa6, 16'h5462,
              16'h5967, 16'h5eb7, 16'h6459, 16'h6a51, 16'h70a3, 16'h7756, 16'h7e6f};
        ftab = (i < 7'd84) ? t[i] : t[83];
    endfunction

    // quarter sine magnitude, sign from phase bit 5
    function automatic logic signed [7:0] sine64(input logic [5:0] ph);
        logic [6:0] q [17];
        logic [4:0] k;
        logic [6:0] m;
        q = '{7'd0, 7'd12, 7'd25, 7'd37, 7'd49, 7'd60, 7'd71, 7'd81, 7'd90,
              7'd98, 7'd106, 7'd112, 7'd117, 7'd122, 7'd125, 7'd126, 7'd127};
        k = ph[4] ? 5'(6'd32 - {2'b0, ph[3:0]} - 6'd16) : {1'b0, ph[3:0]};
        if (ph[4]) k = 5'(5'd16 - {1'b0, ph[3:0]});
        m = q[k];
        sine64 = ph[5] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

// ===== sv/chiptune_voice_modulator_unit.sv =====
// Four-voice chiptune effect engine. The item kind travels on s_tuser: a command or a
// trigger is taken in the cycle it is accepted, so these items can follow back to back.
// A tick walks the voices one per cycle, while the output is not stalled, through a
// single shared voice datapath and emits one result item per voice. The next item is
// accepted only after every voice has been computed and the final result has drained;
// while m_tready is held low with a result waiting, the walk stalls.
// s_tready is low while a tick is being walked or a result waits.
module chiptune_voice_modulator_unit import cvm_pkg::*; #(
    parameter int VOICES = DEF_VOICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // chan, cmd, param, note, restart, pad
    input  logic [1:0]  s_tuser,  // kind
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [55:0] m_tdata,  // voice, freq, volume, duty, waveform, pad
    output logic        m_tlast   // last
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [7:0]  base_note_reg [VOICES];
    logic [7:0]  pitch_note_reg [VOICES];
    logic [15:0] bend_acc_reg [VOICES];
    logic [7:0]  bend_step_reg [VOICES];
    logic [7:0]  vol_step_reg [VOICES];
    logic [15:0] duty_step_reg [VOICES];
    logic [3:0]  vib_depth_reg [VOICES];
    logic [3:0]  vib_rate_reg [VOICES];
    logic [7:0]  vib_phase_reg [VOICES];
    logic [8:0]  glide_rate_reg [VOICES];
    logic [15:0] glide_freq_reg [VOICES];
    logic [7:0]  cur_volume_reg [VOICES];
    logic [15:0] cur_duty_reg [VOICES];
    logic [7:0]  wave_sel_reg [VOICES];

    logic          busy_reg;
    logic [VW-1:0] v_reg;
    logic          mv_reg;
    logic [55:0]   m_tdata_reg;
    logic          m_tlast_reg;

    logic [1:0] kind, chan;
    logic [3:0] cmd;
    logic [7:0] param, note;
    logic       restart;
    logic [VW-1:0] ci;
    assign kind = s_tuser;
    assign chan = s_tdata[1:0];
    assign cmd = s_tdata[5:2];
    assign param = s_tdata[13:6];
    assign note = s_tdata[21:14];
    assign restart = s_tdata[22];
    assign ci = VW'(chan);

    logic [15:0] slide, freq, duty;
    logic [7:0]  volume;

    cvm_voice_alu u_alu (
        .pitch_note(pitch_note_reg[v_reg]), .glide_rate(glide_rate_reg[v_reg]),
        .glide_freq(glide_freq_reg[v_reg]), .bend_acc(bend_acc_reg[v_reg]),
        .vib_depth(vib_depth_reg[v_reg]), .vib_phase(vib_phase_reg[v_reg]),
        .cur_volume(cur_volume_reg[v_reg]), .vol_step(vol_step_reg[v_reg]),
        .cur_duty(cur_duty_reg[v_reg]), .duty_step(duty_step_reg[v_reg]),
        .slide(slide), .freq(freq), .volume(volume), .duty(duty)
    );

    assign s_tready = !busy_reg && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

    logic accept, step;
    assign accept = s_tvalid && s_tready;
    // a voice is computed when the output slot is free or being drained
    assign step = busy_reg && (!mv_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mv_reg <= 1'b0;
            v_reg <= '0;
            m_tdata_reg <= '0;
            m_tlast_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                base_note_reg[i] <= '0; pitch_note_reg[i] <= '0; bend_acc_reg[i] <= '0;
                bend_step_reg[i] <= '0; vol_step_reg[i] <= '0; duty_step_reg[i] <= '0;
                vib_depth_reg[i] <= '0; vib_rate_reg[i] <= '0; vib_phase_reg[i] <= '0;
                glide_rate_reg[i] <= '0; glide_freq_reg[i] <= '0;
                cur_volume_reg[i] <= '0; cur_duty_reg[i] <= '0; wave_sel_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                if (kind == KIND_TICK) begin
                    busy_reg <= 1'b1;
                    v_reg <= '0;
                end else if (32'(chan) < VOICES) begin
                    if (kind == KIND_CMD) begin
                        case (cmd)
                            FX_DUTY:   cur_duty_reg[ci] <= {param, 8'h00};
                            FX_VSLIDE: vol_step_reg[ci] <= param;
                            FX_GLIDE:  glide_rate_reg[ci] <= {param, 1'b0};
                            FX_BEND:   bend_step_reg[ci] <= param;
                            FX_SWEEP:  duty_step_reg[ci] <= {2'b0, param, 6'b0};
                            FX_VOL:    cur_volume_reg[ci] <= param;
                            FX_WAVE:   wave_sel_reg[ci] <= param;
                            FX_VIB: begin
                                if (vib_depth_reg[ci] != param[7:4])
                                    vib_phase_reg[ci] <= '0;
                                vib_depth_reg[ci] <= param[7:4];
                                vib_rate_reg[ci] <= param[3:0];
                            end
                            FX_RELN: pitch_note_reg[ci] <=
                                8'(param + base_note_reg[ci] - NOTE_OFS);
                            FX_ABSN: pitch_note_reg[ci] <= param;
                            default: ;
                        endcase
                    end else if (kind == KIND_TRIG) begin
                        if (note != 8'd0) base_note_reg[ci] <= note;
                        if (restart) begin
                            bend_acc_reg[ci] <= '0;
                            bend_step_reg[ci] <= '0;
                            vol_step_reg[ci] <= '0;
                            duty_step_reg[ci] <= '0;
                            vib_depth_reg[ci] <= '0;
                        end
                    end
                end
            end
            if (step) begin
                mv_reg <= 1'b1;
                m_tdata_reg <= {6'b0, wave_sel_reg[v_reg], duty, volume, freq, 2'(v_reg)};
                m_tlast_reg <= (32'(v_reg) == VOICES - 1);
                if (glide_rate_reg[v_reg] != 9'd0) glide_freq_reg[v_reg] <= slide;
                bend_acc_reg[v_reg] <= 16'(bend_acc_reg[v_reg] +
                                           {{8{bend_step_reg[v_reg][7]}}, bend_step_reg[v_reg]});
                cur_volume_reg[v_reg] <= volume;
                cur_duty_reg[v_reg] <= duty;
                vib_phase_reg[v_reg] <= 8'(vib_phase_reg[v_reg] + {4'b0, vib_rate_reg[v_reg]});
                if (32'(v_reg) == VOICES - 1) busy_reg <= 1'b0;
                else v_reg <= VW'(v_reg + 1'b1);
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/cvm_voice_alu.sv =====
// shared per-voice tick datapath: glide, vibrato, volume and duty updates
// depends on cvm_pkg
module cvm_voice_alu import cvm_pkg::*; (
    input  logic [7:0]  pitch_note,
    input  logic [8:0]  glide_rate,
    input  logic [15:0] glide_freq,
    input  logic [15:0] bend_acc,
    input  logic [3:0]  vib_depth,
    input  logic [7:0]  vib_phase,
    input  logic [7:0]  cur_volume,
    input  logic [7:0]  vol_step,
    input  logic [15:0] cur_duty,
    input  logic [15:0] duty_step,
    output logic [15:0] slide,
    output logic [15:0] freq,
    output logic [7:0]  volume,
    output logic [15:0] duty
);
    logic [7:0]  idx;
    logic [15:0] target;
    logic signed [16:0] diff, lim;
    logic signed [12:0] prod, vib;
    logic signed [9:0]  vsum;
    logic [15:0] dsum;

    always_comb begin
        idx = (pitch_note > MAX_NOTE) ? MAX_NOTE : pitch_note;
        target = ftab(idx[6:0]);
        diff = 17'($signed(target - glide_freq));
        lim = $signed({8'b0, glide_rate});
        if (diff > lim) diff = lim;
        if (diff < -lim) diff = -lim;
        slide = (glide_rate != 9'd0) ? 16'(glide_freq + diff[15:0]) : target;
        prod = $signed({9'b0, vib_depth}) * 13'(sine64(vib_phase[5:0]));
        // on the divide by four, positive products round toward zero, negative ones away from zero
        vib = prod[12] ? -((-prod + 13'sd3) >>> 2) : (prod >>> 2);
        freq = 16'(slide + bend_acc + 16'(vib));
        vsum = $signed({2'b0, cur_volume}) + 10'($signed(vol_step));
        volume = (vsum < 0) ? 8'd0 : (vsum > 10'sd255) ? 8'd255 : vsum[7:0];
        dsum = 16'(cur_duty + duty_step);
        if (dsum > DUTY_HI) dsum = DUTY_LO;
        if (dsum < DUTY_LO) dsum = DUTY_HI;
        duty = dsum;
    end
endmodule

// ===== test/tb_chiptune_voice_modulator_unit.sv =====
// testbench for chiptune_voice_modulator_unit: commands, triggers and ticks on the
// input stream, voice results checked against a local behavioral predictor
// depends on cvm_pkg and the unit rtl
module tb_chiptune_voice_modulator_unit import cvm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 4;
    localparam int WDOG_LIMIT = 300;
    localparam int NDIR = 29;
    localparam int NRAND = 431;

    // codes that the block ignores
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [3:0] FX_NONE   = 4'd0;

    typedef struct packed {
        logic [1:0]  voice;
        logic [15:0] freq;
        logic [7:0]  volume;
        logic [15:0] duty;
        logic [7:0]  waveform;
        logic        last;
    } voice_out_t;

    typedef struct {
        logic [1:0] kind;
        logic [1:0] chan;
        logic [3:0] cmd;
        logic [7:0] param;
        logic [7:0] note;
        logic       restart;
        logic       has_exp;
        logic [15:0] exp_freq;
        logic [7:0]  exp_vol;
        logic [15:0] exp_duty;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        m_tvalid;
    logic [55:0] m_tdata;
    logic        m_tlast;

    chiptune_voice_modulator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state per voice
    logic [7:0]  p_base [NV];
    logic [7:0]  p_pitch [NV];
    logic [15:0] p_bend_acc [NV];
    logic [7:0]  p_bend_step [NV];
    logic [7:0]  p_vol_step [NV];
    logic [15:0] p_duty_step [NV];
    logic [3:0]  p_vib_depth [NV];
    logic [3:0]  p_vib_rate [NV];
    logic [7:0]  p_vib_phase [NV];
    logic [8:0]  p_glide_rate [NV];
    logic [15:0] p_glide_freq [NV];
    logic [7:0]  p_volume [NV];
    logic [15:0] p_duty [NV];
    logic [7:0]  p_wave [NV];

    voice_out_t voice_results_q[$];
    int errors = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int items_sent = 0;
    int wdog = 0;

    function automatic logic [15:0] note_freq(input logic [7:0] n);
        logic [15:0] t [84];
        t = '{16'h010b, 16'h011b, 16'h012c, 16'h013e, 16'h0151, 16'h0165, 16'h017a,
              16'h0191, 16'h01a9, 16'h01c2, 16'h01dd, 16'h01f9, 16'h0217, 16'h0237,
              16'h0259, 16'h027d, 16'h02a3, 16'h02cb, 16'h02f5, 16'h0322, 16'h0352,
              16'h0385, 16'h03ba, 16'h03f3, 16'h042f, 16'h046f, 16'h04b2, 16'h04fa,
              16'h0546, 16'h0596, 16'h05eb, 16'h0645, 16'h06a5, 16'h070a, 16'h0775,
              16'h07e6, 16'h085f, 16'h08de, 16'h0965, 16'h09f4, 16'h0a8c, 16'h0b2c,
              16'h0bd6, 16'h0c8b, 16'h0d4a, 16'h0e14, 16'h0eea, 16'h0fcd, 16'h10be,
              16'h11bd, 16'h12cb, 16'h13e9, 16'h1518, 16'h1659, 16'h17ad, 16'h1916,
              16'h1a94, 16'h1c28, 16'h1dd5, 16'h1f9b, 16'h217c, 16'h237a, 16'h2596,
              16'h27d3, 16'h2a31, 16'h2cb3, 16'h2f5b, 16'h322c, 16'h3528, 16'h3851,
              16'h3bab, 16'h3f37, 16'h42f9, 16'h46f5, 16'h4b2d, 16'h4fa6, 16'h5462,
              16'h5967, 16'h5eb7, 16'h6459, 16'h6a51, 16'h70a3, 16'h7756, 16'h7e6f};
        return (n > MAX_NOTE) ? t[83] : t[n];
    endfunction

    function automatic int sine_of(input logic [5:0] ph);
        int q [17];
        int k;
        q = '{0, 12, 25, 37, 49, 60, 71, 81, 90, 98, 106, 112, 117, 122, 125, 126, 127};
        k = ph[4] ? 16 - int'(ph[3:0]) : int'(ph[3:0]);
        return ph[5] ? -q[k] : q[k];
    endfunction

    task automatic clear_voices();
        for (int v = 0; v < NV; v++) begin
            p_base[v] = '0; p_pitch[v] = '0; p_bend_acc[v] = '0; p_bend_step[v] = '0;
            p_vol_step[v] = '0; p_duty_step[v] = '0; p_vib_depth[v] = '0;
            p_vib_rate[v] = '0; p_vib_phase[v] = '0; p_glide_rate[v] = '0;
            p_glide_freq[v] = '0; p_volume[v] = '0; p_duty[v] = '0; p_wave[v] = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
    endtask

    task automatic predict(input stim_row_t row);
        logic [1:0] ch;
        logic [7:0] prm;
        logic [15:0] target;
        logic [15:0] slide;
        logic [15:0] dsum;
        int diff;
        int lim;
        int vib;
        int vol;
        voice_out_t r;
        ch = row.chan;
        prm = row.param;
        if (row.kind == KIND_CMD) begin
            case (row.cmd)
                FX_DUTY:   p_duty[ch] = {prm, 8'h00};
                FX_VSLIDE: p_vol_step[ch] = prm;
                FX_GLIDE:  p_glide_rate[ch] = {prm, 1'b0};
                FX_BEND:   p_bend_step[ch] = prm;
                FX_SWEEP:  p_duty_step[ch] = {2'b00, prm, 6'b0};
                FX_VOL:    p_volume[ch] = prm;
                FX_WAVE:   p_wave[ch] = prm;
                FX_VIB: begin
                    if (p_vib_depth[ch] != prm[7:4]) p_vib_phase[ch] = '0;
                    p_vib_depth[ch] = prm[7:4];
                    p_vib_rate[ch] = prm[3:0];
                end
                FX_RELN:   p_pitch[ch] = 8'(prm + p_base[ch] - NOTE_OFS);
                FX_ABSN:   p_pitch[ch] = prm;
                default: ;
            endcase
        end else if (row.kind == KIND_TRIG) begin
            if (row.note != 8'd0) p_base[ch] = row.note;
            if (row.restart) begin
                p_bend_acc[ch] = '0; p_bend_step[ch] = '0; p_vol_step[ch] = '0;
                p_duty_step[ch] = '0; p_vib_depth[ch] = '0;
            end
        end else if (row.kind == KIND_TICK) begin
            for (int v = 0; v < NV; v++) begin
                target = note_freq(p_pitch[v]);
                if (p_glide_rate[v] != 0) begin
                    diff = int'($signed(16'(target - p_glide_freq[v])));
                    lim = int'(p_glide_rate[v]);
                    if (diff > lim) diff = lim;
                    if (diff < -lim) diff = -lim;
                    slide = 16'(int'(p_glide_freq[v]) + diff);
                    p_glide_freq[v] = slide;
                end else begin
                    slide = target;
                end
                vib = int'(p_vib_depth[v]) * sine_of(p_vib_phase[v][5:0]);
                vib = (vib < 0) ? -((-vib + 3) / 4) : vib / 4;
                r.freq = 16'(int'(slide) + int'(p_bend_acc[v]) + vib);
                p_bend_acc[v] = 16'(int'(p_bend_acc[v]) + int'($signed(p_bend_step[v])));
                vol = int'(p_volume[v]) + int'($signed(p_vol_step[v]));
                if (vol < 0) vol = 0;
                if (vol > 255) vol = 255;
                p_volume[v] = vol[7:0];
                dsum = 16'(p_duty[v] + p_duty_step[v]);
                if (dsum > DUTY_HI) dsum = DUTY_LO;
                if (dsum < DUTY_LO) dsum = DUTY_HI;
                p_duty[v] = dsum;
                p_vib_phase[v] = 8'(p_vib_phase[v] + {4'b0, p_vib_rate[v]});
                r.voice = v[1:0];
                r.volume = p_volume[v];
                r.duty = p_duty[v];
                r.waveform = p_wave[v];
                r.last = (v == NV - 1);
                // typed values of a table row are checked on the voice it names
                if (row.has_exp && v == int'(row.chan)) begin
                    if (r.freq != row.exp_freq) report_mismatch("table freq", r.freq, row.exp_freq);
                    if (r.volume != row.exp_vol) report_mismatch("table volume", r.volume, row.exp_vol);
                    if (r.duty != row.exp_duty) report_mismatch("table duty", r.duty, row.exp_duty);
                    r.freq = row.exp_freq;
                    r.volume = row.exp_vol;
                    r.duty = row.exp_duty;
                end
                voice_results_q.push_back(r);
            end
        end
    endtask

    // result side: random stalls and compare against oldest expectation
    logic [3:0] m_wait = '0;
    always @(posedge aclk) begin
        voice_out_t e;
        int w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (voice_results_q.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[31:0], 32'd0);
                end else begin
                    e = voice_results_q.pop_front();
                    if (m_tdata[1:0] != e.voice) report_mismatch("voice", m_tdata[1:0], e.voice);
                    if (m_tdata[17:2] != e.freq) report_mismatch("freq", m_tdata[17:2], e.freq);
                    if (m_tdata[25:18] != e.volume)
                        report_mismatch("volume", m_tdata[25:18], e.volume);
                    if (m_tdata[41:26] != e.duty) report_mismatch("duty", m_tdata[41:26], e.duty);
                    if (m_tdata[49:42] != e.waveform)
                        report_mismatch("waveform", m_tdata[49:42], e.waveform);
                    if (m_tlast != e.last) report_mismatch("last", m_tlast, e.last);
                end
                w = $urandom_range(0, 9);
                m_wait <= 4'(w);
                m_tready <= (w == 0);
            end else if (m_wait != 4'd0) begin
                m_wait <= m_wait - 4'd1;
                m_tready <= (m_wait == 4'd1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on acceptance activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", WDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input stim_row_t row, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser <= row.kind;
        s_tdata <= {1'b0, row.restart, row.note, row.param, row.cmd, row.chan};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict(row);
        items_sent++;
        if (row.kind == KIND_TICK) ticks_sent++;
    endtask

    // hold the input until every expected result has come
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (voice_results_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        stim_row_t dir_rows [NDIR];
        stim_row_t row;
        int pick;
        dir_rows = '{
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b1, 16'h010b, 8'd0, 16'he000},
            '{KIND_CMD, 2'd1, FX_ABSN, 8'd255, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd1, FX_VOL, 8'd250, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd1, FX_VSLIDE, 8'd10, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd1, FX_DUTY, 8'hff, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd1, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b1, 16'h7e6f, 8'd255, 16'h2000},
            '{KIND_CMD, 2'd2, FX_VOL, 8'd5, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd2, FX_VSLIDE, 8'h80, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd2, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b1, 16'h010b, 8'd0, 16'he000},
            '{KIND_TRIG, 2'd3, FX_NONE, 8'd0, 8'd60, 1'b1, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd3, FX_RELN, 8'd50, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd3, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b1, 16'h2596, 8'd0, 16'he000},
            '{KIND_CMD, 2'd0, FX_GLIDE, 8'h40, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd0, FX_ABSN, 8'd40, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd0, FX_BEND, 8'hfd, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd0, FX_SWEEP, 8'h90, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd0, FX_VIB, 8'h53, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd0, FX_WAVE, 8'd7, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd0, FX_VIB, 8'h57, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_CMD, 2'd1, FX_NONE, 8'h55, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_NONE, 2'd1, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TRIG, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TRIG, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b1, 1'b0, 16'h0, 8'd0, 16'h0},
            '{KIND_TICK, 2'd0, FX_NONE, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 8'd0, 16'h0}
        };
        clear_voices();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++) begin
            send_item(dir_rows[i], 1'b1);
        end
        drain();

        for (int i = 0; i < NRAND; i++) begin
            pick = $urandom_range(0, 19);
            row.kind = (pick < 10) ? KIND_CMD : (pick < 13) ? KIND_TRIG :
                       (pick < 19) ? KIND_TICK : KIND_NONE;
            row.chan = 2'($urandom_range(0, 3));
            row.cmd = 4'($urandom_range(0, 15));
            row.param = 8'($urandom_range(0, 255));
            row.note = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            row.restart = 1'($urandom_range(0, 1));
            row.has_exp = 1'b0;
            row.exp_freq = '0;
            row.exp_vol = '0;
            row.exp_duty = '0;
            send_item(row, 1'b1);
            if (i % 100 == 99) drain();
        end
        drain();
        repeat (20) @(posedge aclk);

        $display("sent %0d items with %0d ticks, %0d voice results checked", items_sent,
                 ticks_sent, results_seen);
        $display("directed effect, trigger and clamp cases, then random mixes under stalls");
        if (errors == 0 && voice_results_q.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cvm_pkg.sv
sv/cvm_voice_alu.sv
sv/chiptune_voice_modulator_unit.sv
test/tb_chiptune_voice_modulator_unit.sv
